FILE: hdl/smm_pkg.sv
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants for the sound board memory map.
// ----------------------------------------------------------------------------
package smm_pkg;

  // Store sizes
  localparam int PROGRAM_WORDS = 16384;
  localparam int DATA_WORDS    = 16384;
  localparam int SOUND_WORDS   = 8388608;
  localparam int QUEUE_DEPTH   = 4;

  localparam int PROG_AW  = $clog2(PROGRAM_WORDS);
  localparam int DATA_AW  = $clog2(DATA_WORDS);
  localparam int SND_AW   = $clog2(SOUND_WORDS);
  localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

  // Field widths
  localparam int ACTION_W = 3;
  localparam int ADDR_W   = 14;
  localparam int RIDX_W   = 23;
  localparam int VALUE_W  = 24;
  localparam int BANK_W   = 11;
  localparam int BYTE_W   = 8;
  localparam int HALF_W   = 16;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_DATA_RD  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DATA_WR  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PROG_RD  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_PROG_WR  = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_HOST     = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_ROM_LOAD = 3'd5;

  // Data-space decode boundaries
  localparam logic [ADDR_W-1:0] SHARED_END = 14'h2000;
  localparam logic [ADDR_W-1:0] ROM_END    = 14'h3000;
  localparam logic [ADDR_W-1:0] BANK_LO    = 14'h3000;
  localparam logic [ADDR_W-1:0] BANK_HI    = 14'h33ff;
  localparam logic [ADDR_W-1:0] LATCH_LO   = 14'h3400;
  localparam logic [ADDR_W-1:0] LATCH_HI   = 14'h37ff;
  localparam logic [ADDR_W-1:0] SHARED_BASE = 14'h0800;

  // Sound words always carry 0xff in the upper byte
  localparam logic [BYTE_W-1:0] ROM_HIGH = 8'hff;
  localparam logic [BYTE_W-1:0] ROM_FILL = 8'hff;

  // Classified operation
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHARED_RD,
    OP_ROM_RD,
    OP_LATCH_RD,
    OP_DATA_RD,
    OP_SHARED_WR,
    OP_DATA_WR,
    OP_BANK_WR,
    OP_PROG_RD,
    OP_PROG_WR,
    OP_HOST,
    OP_ROM_LOAD
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [ADDR_W-1:0]   address;
    logic [RIDX_W-1:0]   rom_index;
    logic [VALUE_W-1:0]  value;
  } op_t;

  // Back end sequencer state
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } back_state_t;

endpackage

FILE: hdl/smm_ram.sv
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; read data holds when not enabled
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/smm_front.sv
// ----------------------------------------------------------------------------
// smm_front
// Accepts access requests and classifies them by action and address window.
// ----------------------------------------------------------------------------
module smm_front (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smm_pkg::ACTION_W-1:0]  in_action,
  input  logic [smm_pkg::ADDR_W-1:0]    in_address,
  input  logic [smm_pkg::RIDX_W-1:0]    in_rom_index,
  input  logic [smm_pkg::VALUE_W-1:0]   in_value,
  input  logic                          q_full,
  input  logic                          clearing,
  output logic                          push,
  output smm_pkg::op_t                  push_op
);

  // Hold off requests while the queue is full or the stores are being swept
  assign in_stall = q_full | clearing;
  assign push     = in_valid & ~in_stall;

  // Classify the request
  always_comb begin
    push_op.address   = in_address;
    push_op.rom_index = in_rom_index;
    push_op.value     = in_value;
    unique case (in_action)
      smm_pkg::ACT_DATA_RD: begin
        if (in_address < smm_pkg::SHARED_END) begin
          push_op.kind = smm_pkg::OP_SHARED_RD;
        end else if (in_address < smm_pkg::ROM_END) begin
          push_op.kind = smm_pkg::OP_ROM_RD;
        end else if (in_address >= smm_pkg::LATCH_LO && in_address <= smm_pkg::LATCH_HI) begin
          push_op.kind = smm_pkg::OP_LATCH_RD;
        end else begin
          push_op.kind = smm_pkg::OP_DATA_RD;
        end
      end
      smm_pkg::ACT_DATA_WR: begin
        if (in_address < smm_pkg::SHARED_END) begin
          push_op.kind = smm_pkg::OP_SHARED_WR;
        end else if (in_address >= smm_pkg::BANK_LO && in_address <= smm_pkg::BANK_HI) begin
          push_op.kind = smm_pkg::OP_BANK_WR;
        end else begin
          push_op.kind = smm_pkg::OP_DATA_WR;
        end
      end
      smm_pkg::ACT_PROG_RD:  push_op.kind = smm_pkg::OP_PROG_RD;
      smm_pkg::ACT_PROG_WR:  push_op.kind = smm_pkg::OP_PROG_WR;
      smm_pkg::ACT_HOST:     push_op.kind = smm_pkg::OP_HOST;
      smm_pkg::ACT_ROM_LOAD: push_op.kind = smm_pkg::OP_ROM_LOAD;
      default:               push_op.kind = smm_pkg::OP_NONE;
    endcase
  end

endmodule

FILE: hdl/smm_queue.sv
// ----------------------------------------------------------------------------
// smm_queue
// Short FIFO of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module smm_queue (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  smm_pkg::op_t push_op,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output smm_pkg::op_t head_op
);

  smm_pkg::op_t                  entry_r [smm_pkg::QUEUE_DEPTH];
  logic [smm_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [smm_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [smm_pkg::QUEUE_AW:0]    count_r, count_nxt;

  assign full       = (count_r == (smm_pkg::QUEUE_AW+1)'(smm_pkg::QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = entry_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

FILE: hdl/smm_back.sv
// ----------------------------------------------------------------------------
// smm_back
// Executes operations against the stores, the bank register and the host
// latch, and drives the result register. Sweeps the stores after reset.
// ----------------------------------------------------------------------------
module smm_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  smm_pkg::op_t                  q_op,
  output logic                          q_pop,
  output logic                          clearing,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smm_pkg::VALUE_W-1:0]   out_read_data,
  output logic                          out_irq_request,
  output logic                          out_latch_busy
);

  smm_pkg::back_state_t state_r, state_nxt;
  logic [smm_pkg::SND_AW-1:0] clr_cnt_r, clr_cnt_nxt;

  // Architectural registers
  logic [smm_pkg::BANK_W-1:0] bank_r, bank_nxt;
  logic [smm_pkg::BYTE_W-1:0] latch_r, latch_nxt;
  logic                       full_r, full_nxt;

  // Execute stage (waits on registered RAM read data)
  logic                       exe_valid_r, exe_valid_nxt;
  smm_pkg::op_kind_t          exe_kind_r;
  logic [smm_pkg::BYTE_W-1:0] exe_latch_r;
  logic                       exe_full_r;
  logic                       exe_adv;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic [smm_pkg::VALUE_W-1:0] out_data_r, out_data_nxt;
  logic                        out_full_r;

  // RAM ports
  logic                        ph_we, pl_we, dm_we, sn_we;
  logic [smm_pkg::PROG_AW-1:0] ph_wa, pl_wa, ph_ra, pl_ra;
  logic [smm_pkg::DATA_AW-1:0] dm_wa, dm_ra;
  logic [smm_pkg::SND_AW-1:0]  sn_wa, sn_ra;
  logic [smm_pkg::HALF_W-1:0]  ph_wd, ph_rd, dm_wd, dm_rd;
  logic [smm_pkg::BYTE_W-1:0]  pl_wd, pl_rd, sn_wd, sn_rd;
  logic                        ph_re, pl_re, dm_re, sn_re;
  logic [smm_pkg::ADDR_W-1:0]  shared_addr;
  logic [smm_pkg::PROG_AW-1:0] shared_idx;

  assign clearing = (state_r == smm_pkg::ST_CLEAR);

  // Result register advances when empty or being taken
  assign exe_adv = exe_valid_r & (~out_valid_r | ~out_stall);
  assign q_pop   = ~clearing & q_valid & (~exe_valid_r | exe_adv);

  // Shared program window: upper 16 bits of program words, offset from the shared base
  assign shared_addr = smm_pkg::SHARED_BASE
                     + {{(smm_pkg::ADDR_W-11){1'b0}}, q_op.address[10:0]};
  assign shared_idx  = shared_addr[smm_pkg::PROG_AW-1:0];

  // Sequencer: clearing sweep, then issue
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    bank_nxt    = bank_r;
    latch_nxt   = latch_r;
    full_nxt    = full_r;
    ph_we = 1'b0; pl_we = 1'b0; dm_we = 1'b0; sn_we = 1'b0;
    ph_re = 1'b0; pl_re = 1'b0; dm_re = 1'b0; sn_re = 1'b0;
    ph_wa = q_op.address[smm_pkg::PROG_AW-1:0];
    pl_wa = q_op.address[smm_pkg::PROG_AW-1:0];
    ph_ra = q_op.address[smm_pkg::PROG_AW-1:0];
    pl_ra = q_op.address[smm_pkg::PROG_AW-1:0];
    dm_wa = q_op.address[smm_pkg::DATA_AW-1:0];
    dm_ra = q_op.address[smm_pkg::DATA_AW-1:0];
    sn_wa = q_op.rom_index[smm_pkg::SND_AW-1:0];
    sn_ra = {bank_r, q_op.address[11:0]};
    ph_wd = q_op.value[smm_pkg::VALUE_W-1:smm_pkg::BYTE_W];
    pl_wd = q_op.value[smm_pkg::BYTE_W-1:0];
    dm_wd = q_op.value[smm_pkg::HALF_W-1:0];
    sn_wd = q_op.value[smm_pkg::BYTE_W-1:0];
    unique case (state_r)
      smm_pkg::ST_CLEAR: begin
        // Sweep every store to its reset value
        ph_we = 1'b1; pl_we = 1'b1; dm_we = 1'b1; sn_we = 1'b1;
        ph_wa = clr_cnt_r[smm_pkg::PROG_AW-1:0];
        pl_wa = clr_cnt_r[smm_pkg::PROG_AW-1:0];
        dm_wa = clr_cnt_r[smm_pkg::DATA_AW-1:0];
        sn_wa = clr_cnt_r;
        ph_wd = '0;
        pl_wd = '0;
        dm_wd = '0;
        sn_wd = smm_pkg::ROM_FILL;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == smm_pkg::SND_AW'(smm_pkg::SOUND_WORDS - 1)) begin
          state_nxt = smm_pkg::ST_RUN;
        end
      end
      smm_pkg::ST_RUN: begin
        if (q_pop) begin
          case (q_op.kind)
            smm_pkg::OP_SHARED_RD: begin
              ph_re = 1'b1;
              ph_ra = shared_idx;
            end
            smm_pkg::OP_ROM_RD:  sn_re = 1'b1;
            smm_pkg::OP_LATCH_RD: full_nxt = 1'b0;
            smm_pkg::OP_DATA_RD: dm_re = 1'b1;
            smm_pkg::OP_SHARED_WR: begin
              ph_we = 1'b1;
              ph_wa = shared_idx;
              ph_wd = q_op.value[smm_pkg::HALF_W-1:0];
            end
            smm_pkg::OP_DATA_WR: dm_we = 1'b1;
            smm_pkg::OP_BANK_WR: begin
              dm_we    = 1'b1;
              bank_nxt = q_op.value[smm_pkg::BANK_W-1:0];
            end
            smm_pkg::OP_PROG_RD: begin
              ph_re = 1'b1;
              pl_re = 1'b1;
            end
            smm_pkg::OP_PROG_WR: begin
              ph_we = 1'b1;
              pl_we = 1'b1;
            end
            smm_pkg::OP_HOST: begin
              latch_nxt = q_op.value[smm_pkg::BYTE_W-1:0];
              full_nxt  = 1'b1;
            end
            smm_pkg::OP_ROM_LOAD: sn_we = 1'b1;
            default: ;
          endcase
        end
      end
      default: state_nxt = smm_pkg::ST_CLEAR;
    endcase
  end

  // Execute stage and result register control
  always_comb begin
    exe_valid_nxt = exe_valid_r;
    if (q_pop) begin
      exe_valid_nxt = 1'b1;
    end else if (exe_adv) begin
      exe_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (exe_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Form read data from the RAM outputs
  always_comb begin
    case (exe_kind_r)
      smm_pkg::OP_SHARED_RD: out_data_nxt = {8'h00, ph_rd};
      smm_pkg::OP_ROM_RD:    out_data_nxt = {8'h00, smm_pkg::ROM_HIGH, sn_rd};
      smm_pkg::OP_LATCH_RD:  out_data_nxt = {16'h0000, exe_latch_r};
      smm_pkg::OP_DATA_RD:   out_data_nxt = {8'h00, dm_rd};
      smm_pkg::OP_PROG_RD:   out_data_nxt = {ph_rd, pl_rd};
      default:               out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      bank_r      <= '0;
      latch_r     <= '0;
      full_r      <= 1'b0;
      exe_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      bank_r      <= bank_nxt;
      latch_r     <= latch_nxt;
      full_r      <= full_nxt;
      exe_valid_r <= exe_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      exe_kind_r  <= q_op.kind;
      exe_latch_r <= latch_r;
      exe_full_r  <= full_nxt;
    end
    if (exe_adv) begin
      out_data_r <= out_data_nxt;
      out_full_r <= exe_full_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;
  assign out_irq_request = out_full_r;
  assign out_latch_busy  = out_full_r;

  // Program store, upper 16 bits
  smm_ram #(.WIDTH(smm_pkg::HALF_W), .DEPTH(smm_pkg::PROGRAM_WORDS)) u_prog_hi (
    .clk(clk), .wr_en(ph_we), .wr_addr(ph_wa), .wr_data(ph_wd),
    .rd_en(ph_re), .rd_addr(ph_ra), .rd_data(ph_rd)
  );

  // Program store, lower 8 bits
  smm_ram #(.WIDTH(smm_pkg::BYTE_W), .DEPTH(smm_pkg::PROGRAM_WORDS)) u_prog_lo (
    .clk(clk), .wr_en(pl_we), .wr_addr(pl_wa), .wr_data(pl_wd),
    .rd_en(pl_re), .rd_addr(pl_ra), .rd_data(pl_rd)
  );

  // Data store
  smm_ram #(.WIDTH(smm_pkg::HALF_W), .DEPTH(smm_pkg::DATA_WORDS)) u_data (
    .clk(clk), .wr_en(dm_we), .wr_addr(dm_wa), .wr_data(dm_wd),
    .rd_en(dm_re), .rd_addr(dm_ra), .rd_data(dm_rd)
  );

  // Sound ROM store, low byte only
  smm_ram #(.WIDTH(smm_pkg::BYTE_W), .DEPTH(smm_pkg::SOUND_WORDS)) u_sound (
    .clk(clk), .wr_en(sn_we), .wr_addr(sn_wa), .wr_data(sn_wd),
    .rd_en(sn_re), .rd_addr(sn_ra), .rd_data(sn_rd)
  );

endmodule

FILE: hdl/sound_board_memory_map.sv
// ----------------------------------------------------------------------------
// sound_board_memory_map
// Memory map of a DSP sound board: program, data and banked sound stores,
// bank register and host command latch.
// ----------------------------------------------------------------------------
// After reset the block sweeps its stores to their reset values, one sound
// word per cycle, over all 8388608 (2^23) sound words; in_stall stays high for
// that whole pass. From then on it takes one request per cycle while the queue
// is not full, since every request touches each store RAM through a single
// port at most once, and returns one result per request, in order, through
// the queue, the execute stage that waits on the registered RAM read, and the
// result register. A four-entry queue lets requests keep arriving while
// a result waits on out_stall.
module sound_board_memory_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smm_pkg::ACTION_W-1:0]  in_action,
  input  logic [smm_pkg::ADDR_W-1:0]    in_address,
  input  logic [smm_pkg::RIDX_W-1:0]    in_rom_index,
  input  logic [smm_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smm_pkg::VALUE_W-1:0]   out_read_data,
  output logic                          out_irq_request,
  output logic                          out_latch_busy
);

  logic         push, q_full, q_pop, q_valid, clearing;
  smm_pkg::op_t push_op, q_op;

  // Classify requests
  smm_front u_front (
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_address(in_address), .in_rom_index(in_rom_index), .in_value(in_value),
    .q_full(q_full), .clearing(clearing), .push(push), .push_op(push_op)
  );

  // Decouple front and back
  smm_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_op(push_op), .full(q_full),
    .pop(q_pop), .head_valid(q_valid), .head_op(q_op)
  );

  // Execute against the stores
  smm_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_op(q_op), .q_pop(q_pop),
    .clearing(clearing), .out_valid(out_valid), .out_stall(out_stall),
    .out_read_data(out_read_data), .out_irq_request(out_irq_request),
    .out_latch_busy(out_latch_busy)
  );

endmodule

FILE: hdl/smm_checker.sv
// ----------------------------------------------------------------------------
// smm_checker
// Port-level checks for the sound board memory map.
// ----------------------------------------------------------------------------
module smm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [smm_pkg::VALUE_W-1:0]   out_read_data,
  input logic                          out_irq_request,
  input logic                          out_latch_busy
);

  // IRQ line mirrors the latch flag on every result
  a_irq_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_irq_request == out_latch_busy))
    else $error("irq_request differs from latch_busy");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data)
                               && $stable(out_irq_request))
    else $error("stalled result changed");

  // No result right after reset
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // Requests held off while the stores are swept
  a_rst_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("request taken during clearing pass");

  // Results never carry unknown bits
  a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_read_data, out_irq_request, out_latch_busy}))
    else $error("result carries unknown bits");

endmodule

bind sound_board_memory_map smm_checker u_smm_checker (.*);
